// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL. In synthesis they expand to nothing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Concurrent check that is switched off while reset is held.
`define TSE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that also holds during reset.
`define TSE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TSE_ASSERT(lbl, clk, rst_n, prop, msg)
`define TSE_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// File: design/tse_pkg.sv
// ----------------------------------------------------------------------------
// tse_pkg
// Types and constants of the tab to space expander.
// ----------------------------------------------------------------------------
package tse_pkg;

  // Character codes the expander treats specially.
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_BS    = 8'h08;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // Configuration register map.
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 36;
  localparam logic [CFG_IDX_BITS-1:0] CFG_STOP_COUNT  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_STOP_WORD_0 = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_STOP_WORD_1 = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_STOP_WORD_2 = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_STOP_WORD_3 = 3'd4;

  // Tab stop layout: four nine-bit stops in each of four words.
  localparam int unsigned COUNT_BITS     = 5;
  localparam int unsigned STOP_BITS      = 9;
  localparam int unsigned STOPS_PER_WORD = 4;
  localparam int unsigned STOP_WORDS     = 4;
  localparam int unsigned STOP_SLOTS     = STOPS_PER_WORD * STOP_WORDS;
  localparam int unsigned SLOT_BITS      = 4;
  localparam logic [STOP_BITS-1:0] STOP_MAX = 9'd256;
  localparam logic [STOP_BITS-1:0] STOP_MIN = 9'd1;

  // Width of a run of spaces (1 to 256).
  localparam int unsigned RUN_BITS = 9;
  localparam logic [RUN_BITS-1:0] DEFAULT_TAB = 9'd8;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SUB,
    S_LIST,
    S_OUT
  } tse_state_t;

  // Clamp a raw stop value into 1..256.
  function automatic logic [STOP_BITS-1:0] stop_clamp(input logic [STOP_BITS-1:0] raw);
    logic [STOP_BITS-1:0] v;
    v = raw;
    if (raw == '0) begin
      v = STOP_MIN;
    end else if (raw > STOP_MAX) begin
      v = STOP_MAX;
    end
    return v;
  endfunction

endpackage

// File: design/tab_to_space_expander_core.sv
// ----------------------------------------------------------------------------
// tab_to_space_expander_core
// Tab expansion with column tracking, one result beat per text byte.
// ----------------------------------------------------------------------------
// Each text byte takes one beat in and gives one beat out: the byte to emit
// and a repeat count. Ordinary bytes, backspace, carriage return, newline
// and tabs with the default every-8 stops go straight to the output state.
// With a single interval stop a tab runs the restoring remainder, which
// produces one quotient bit a cycle through the shared subtractor. With a
// stop list a tab scans up to MAX_STOPS stops, as the same subtractor
// compares one stop per cycle. The input stalls while a byte is in work and
// when the finished result cannot leave because the output beat is still
// stalled. Configuration is to be written only while the block is idle;
// the user must keep to this, the block itself does not enforce it.
module tab_to_space_expander_core #(
  parameter int unsigned MAX_STOPS   = 16,
  parameter int unsigned COLUMN_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [tse_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [tse_pkg::CFG_DATA_BITS-1:0] cfg_data,
  // Input channel.
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        in_text_byte,
  input  logic                              in_start_of_file,
  // Result channel.
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        out_byte,
  output logic [tse_pkg::RUN_BITS-1:0]      out_repeat_count,
  output logic                              out_column_saturated
);

  import tse_pkg::*;

  localparam int unsigned BIT_CNT_BITS = $clog2(COLUMN_BITS);
  localparam int unsigned STOP_IDX_BITS = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
  localparam int unsigned UNIT_BITS = COLUMN_BITS + 1;
  localparam logic [COLUMN_BITS-1:0] COL_MAX = '1;

  // Configuration registers.
  logic [COUNT_BITS-1:0]    stop_count_r;
  logic [CFG_DATA_BITS-1:0] stop_word_r [STOP_WORDS];

  // Sequencer and datapath registers.
  tse_state_t               state_r, state_nxt;
  logic [COLUMN_BITS-1:0]   col_r, col_nxt;
  logic [7:0]               byte_r, byte_nxt;
  logic [COLUMN_BITS-1:0]   shr_r, shr_nxt;
  logic [STOP_BITS-1:0]     rem_r, rem_nxt;
  logic [BIT_CNT_BITS-1:0]  bit_r, bit_nxt;
  logic [STOP_IDX_BITS-1:0] k_r, k_nxt;
  logic [RUN_BITS-1:0]      run_r, run_nxt;

  // Output register.
  logic                     out_valid_r, out_valid_nxt;
  logic [7:0]               out_byte_r, out_byte_nxt;
  logic [RUN_BITS-1:0]      out_rep_r, out_rep_nxt;
  logic                     out_sat_r, out_sat_nxt;

  // Stop table view and mode decode.
  logic [STOP_BITS-1:0]     stop_raw [STOP_SLOTS];
  logic [STOP_BITS-1:0]     stop_sel;
  logic [STOP_BITS-1:0]     stop_first;
  logic [COUNT_BITS-1:0]    eff_cnt;
  logic                     last_stop;

  // Shared subtractor.
  logic [UNIT_BITS-1:0]     unit_a, unit_b;
  logic [UNIT_BITS:0]       unit_diff;
  logic                     unit_borrow;

  // Misc combinational terms.
  logic                     in_fire;
  logic                     out_free;
  logic [COLUMN_BITS-1:0]   base_col;
  logic [COLUMN_BITS:0]     col_sum;
  logic [COLUMN_BITS-1:0]   col_final;
  logic [STOP_BITS:0]       div_shift;

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_count_r <= '0;
      for (int w = 0; w < STOP_WORDS; w++) begin
        stop_word_r[w] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STOP_COUNT:  stop_count_r   <= cfg_data[COUNT_BITS-1:0];
        CFG_STOP_WORD_0: stop_word_r[0] <= cfg_data;
        CFG_STOP_WORD_1: stop_word_r[1] <= cfg_data;
        CFG_STOP_WORD_2: stop_word_r[2] <= cfg_data;
        CFG_STOP_WORD_3: stop_word_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Split the stop words into nine-bit slots.
  always_comb begin
    for (int s = 0; s < STOP_SLOTS; s++) begin
      stop_raw[s] = stop_word_r[s / STOPS_PER_WORD][(s % STOPS_PER_WORD) * STOP_BITS +: STOP_BITS];
    end
  end

  // Stop count clamped to the number of supported stops.
  assign eff_cnt    = (stop_count_r > COUNT_BITS'(MAX_STOPS)) ? COUNT_BITS'(MAX_STOPS)
                                                               : stop_count_r;
  assign stop_sel   = stop_clamp(stop_raw[SLOT_BITS'(k_r)]);
  assign stop_first = stop_clamp(stop_raw[0]);
  assign last_stop  = ((COUNT_BITS'(k_r) + COUNT_BITS'(1)) == eff_cnt);

  // Handshake terms.
  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign base_col  = in_start_of_file ? '0 : col_r;
  assign div_shift = {rem_r, shr_r[COLUMN_BITS-1]};

  // Shared subtractor operands per state.
  always_comb begin
    unit_a = '0;
    unit_b = '0;
    case (state_r)
      S_DIV: begin
        unit_a = UNIT_BITS'(div_shift);
        unit_b = UNIT_BITS'(stop_first);
      end
      S_SUB: begin
        unit_a = UNIT_BITS'(stop_first);
        unit_b = UNIT_BITS'(rem_r);
      end
      S_LIST: begin
        unit_a = UNIT_BITS'(stop_sel);
        unit_b = UNIT_BITS'(col_r);
      end
      default: ;
    endcase
  end

  assign unit_diff   = {1'b0, unit_a} - {1'b0, unit_b};
  assign unit_borrow = unit_diff[UNIT_BITS];

  // New column: BS steps back, CR/LF clear it, else adds run, saturating.
  assign col_sum = {1'b0, col_r} + (COLUMN_BITS + 1)'(run_r);
  always_comb begin
    if (byte_r == CHAR_BS) begin
      col_final = (col_r != '0) ? (col_r - COLUMN_BITS'(1)) : col_r;
    end else if ((byte_r == CHAR_CR) || (byte_r == CHAR_LF)) begin
      col_final = '0;
    end else if (col_sum[COLUMN_BITS]) begin
      col_final = COL_MAX;
    end else begin
      col_final = col_sum[COLUMN_BITS-1:0];
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if ((in_text_byte == CHAR_TAB) && (eff_cnt == COUNT_BITS'(1))) begin
            state_nxt = S_DIV;
          end else if ((in_text_byte == CHAR_TAB) && (eff_cnt > COUNT_BITS'(1))) begin
            state_nxt = S_LIST;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_DIV: begin
        if (bit_r == '0) begin
          state_nxt = S_SUB;
        end
      end
      S_SUB: state_nxt = S_OUT;
      S_LIST: begin
        if ((!unit_borrow && (unit_diff != '0)) || last_stop) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and output register updates.
  always_comb begin
    col_nxt       = col_r;
    byte_nxt      = byte_r;
    shr_nxt       = shr_r;
    rem_nxt       = rem_r;
    bit_nxt       = bit_r;
    k_nxt         = k_r;
    run_nxt       = run_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_byte_nxt  = out_byte_r;
    out_rep_nxt   = out_rep_r;
    out_sat_nxt   = out_sat_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          col_nxt  = base_col;
          byte_nxt = in_text_byte;
          shr_nxt  = base_col;
          rem_nxt  = '0;
          bit_nxt  = BIT_CNT_BITS'(COLUMN_BITS - 1);
          k_nxt    = '0;
          if ((in_text_byte == CHAR_TAB) && (eff_cnt == '0)) begin
            run_nxt = DEFAULT_TAB - RUN_BITS'(base_col[2:0]);
          end else begin
            run_nxt = RUN_BITS'(1);
          end
        end
      end
      // One restoring remainder step per cycle, column bits MSB first.
      S_DIV: begin
        shr_nxt = {shr_r[COLUMN_BITS-2:0], 1'b0};
        bit_nxt = bit_r - BIT_CNT_BITS'(1);
        if (unit_borrow) begin
          rem_nxt = div_shift[STOP_BITS-1:0];
        end else begin
          rem_nxt = unit_diff[STOP_BITS-1:0];
        end
      end
      // Run reaches the next multiple of the interval.
      S_SUB: run_nxt = unit_diff[RUN_BITS-1:0];
      // Scan for the first listed stop past the column; if none, run is one.
      S_LIST: begin
        if (!unit_borrow && (unit_diff != '0)) begin
          run_nxt = unit_diff[RUN_BITS-1:0];
        end else if (last_stop) begin
          run_nxt = RUN_BITS'(1);
        end else begin
          k_nxt = k_r + STOP_IDX_BITS'(1);
        end
      end
      // Hand the result to the output register and commit the column.
      S_OUT: begin
        if (out_free) begin
          col_nxt       = col_final;
          out_valid_nxt = 1'b1;
          out_byte_nxt  = (byte_r == CHAR_TAB) ? CHAR_SPACE : byte_r;
          out_rep_nxt   = run_r;
          out_sat_nxt   = (col_final == COL_MAX);
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    shr_r      <= shr_nxt;
    rem_r      <= rem_nxt;
    bit_r      <= bit_nxt;
    k_r        <= k_nxt;
    run_r      <= run_nxt;
    out_byte_r <= out_byte_nxt;
    out_rep_r  <= out_rep_nxt;
    out_sat_r  <= out_sat_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_byte             = out_byte_r;
  assign out_repeat_count     = out_rep_r;
  assign out_column_saturated = out_sat_r;

`include "assert_macros.svh"

  `TSE_ASSERT(a_plain_byte_short, clk, rst_n, in_fire && (in_text_byte != CHAR_TAB) |=> state_r == S_OUT, "non-tab byte did not go straight to output")
  `TSE_ASSERT(a_repeat_nonzero, clk, rst_n, out_valid_r |-> out_rep_r != '0, "result beat with zero repeat count")
  `TSE_ASSERT(a_non_space_single, clk, rst_n, out_valid_r && (out_byte_r != CHAR_SPACE) |-> out_rep_r == RUN_BITS'(1), "non-tab result repeated")
  `TSE_ASSERT(a_div_exit, clk, rst_n, state_r == S_DIV |=> (state_r == S_DIV) || (state_r == S_SUB), "remainder loop left early")
  `TSE_ASSERT(a_div_col_hold, clk, rst_n, state_r == S_DIV |=> $stable(col_r), "column moved during remainder loop")

endmodule
